### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the datagram header parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define TDHP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define TDHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tdhp_pkg.sv
// Package with types, type codes and layout constants of the datagram header parser.
`timescale 1ns / 1ps

package tdhp_pkg;

  localparam int POS_W = 16;
  localparam int MAX_LEN_DEF = 65535;

  // Type byte codes
  localparam logic [7:0] TYPE_INIT   = 8'd1;
  localparam logic [7:0] TYPE_RESP   = 8'd2;
  localparam logic [7:0] TYPE_COOKIE = 8'd3;
  localparam logic [7:0] TYPE_DATA   = 8'd4;

  // Reported message kinds
  localparam logic [1:0] KIND_INIT   = 2'd0;
  localparam logic [1:0] KIND_RESP   = 2'd1;
  localparam logic [1:0] KIND_COOKIE = 2'd2;
  localparam logic [1:0] KIND_DATA   = 2'd3;

  // Datagram sizes
  localparam logic [POS_W-1:0] PREFIX_LEN    = 16'd4;
  localparam logic [POS_W-1:0] INIT_SIZE     = 16'd148;
  localparam logic [POS_W-1:0] RESP_SIZE     = 16'd92;
  localparam logic [POS_W-1:0] COOKIE_SIZE   = 16'd64;
  localparam logic [POS_W-1:0] DATA_MIN_SIZE = 16'd32;
  localparam logic [POS_W-1:0] DATA_HEADER   = 16'd16;

  // MAC field offsets
  localparam logic [7:0] INIT_MAC1 = 8'd116;
  localparam logic [7:0] INIT_MAC2 = 8'd132;
  localparam logic [7:0] RESP_MAC1 = 8'd60;
  localparam logic [7:0] RESP_MAC2 = 8'd76;

  // Gathered view of a datagram, including its current byte
  typedef struct packed {
    logic [POS_W-1:0] len;
    logic [7:0]       type_code;
    logic             reserved_nonzero;
    logic             length_overflow;
    logic [31:0]      sender;
    logic [31:0]      receiver;
    logic [63:0]      counter;
  } tdhp_view_t;

  // One result
  typedef struct packed {
    logic             accepted;
    logic [1:0]       message_kind;
    logic [31:0]      sender_id;
    logic [31:0]      receiver_id;
    logic [63:0]      nonce_counter;
    logic [POS_W-1:0] datagram_length;
    logic [POS_W-1:0] sealed_length;
    logic [7:0]       mac1_offset;
    logic [7:0]       mac2_offset;
  } tdhp_result_t;

endpackage

### rtl/tdhp_gather.sv
// Per-datagram accumulator: byte count, prefix check and index/counter gathering.
`timescale 1ns / 1ps

module tdhp_gather
  import tdhp_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output tdhp_view_t view
);

  logic [POS_W-1:0] pos_r;
  logic [7:0]       type_r;
  logic             rsv_r;
  logic             ovf_r;
  logic [31:0]      sender_r;
  logic [31:0]      receiver_r;
  logic [63:0]      counter_r;

  tdhp_view_t nxt;
  logic       is_hs;
  logic       is_rc;

  // Fold the current byte into the gathered state
  always_comb begin
    nxt.len              = pos_r;
    nxt.type_code        = (pos_r == '0) ? data_byte : type_r;
    nxt.reserved_nonzero = rsv_r;
    nxt.length_overflow  = ovf_r;
    nxt.sender           = sender_r;
    nxt.receiver         = receiver_r;
    nxt.counter          = counter_r;

    is_hs = (nxt.type_code == TYPE_INIT) || (nxt.type_code == TYPE_RESP);
    is_rc = (nxt.type_code == TYPE_COOKIE) || (nxt.type_code == TYPE_DATA);

    // reserved bytes 1..3
    if (pos_r != '0 && pos_r < PREFIX_LEN && data_byte != 8'd0) begin
      nxt.reserved_nonzero = 1'b1;
    end

    // bytes 4..7: sender or receiver index
    if (pos_r >= 16'd4 && pos_r < 16'd8) begin
      if (is_hs) begin
        nxt.sender[8*pos_r[1:0] +: 8] = sender_r[8*pos_r[1:0] +: 8] | data_byte;
      end else if (is_rc) begin
        nxt.receiver[8*pos_r[1:0] +: 8] = receiver_r[8*pos_r[1:0] +: 8] | data_byte;
      end
    end else if (pos_r >= 16'd8 && pos_r < 16'd16) begin
      // bytes 8..15: response receiver or transport counter
      if (nxt.type_code == TYPE_RESP && pos_r < 16'd12) begin
        nxt.receiver[8*pos_r[1:0] +: 8] = receiver_r[8*pos_r[1:0] +: 8] | data_byte;
      end else if (nxt.type_code == TYPE_DATA) begin
        nxt.counter[8*pos_r[2:0] +: 8] = counter_r[8*pos_r[2:0] +: 8] | data_byte;
      end
    end

    // saturating byte count
    if (pos_r < POS_W'(MAX_LEN)) begin
      nxt.len = pos_r + 1'b1;
    end else begin
      nxt.length_overflow = 1'b1;
    end
  end

  assign view = nxt;

  // State registers, cleared after the final byte
  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      pos_r      <= '0;
      type_r     <= '0;
      rsv_r      <= 1'b0;
      ovf_r      <= 1'b0;
      sender_r   <= '0;
      receiver_r <= '0;
      counter_r  <= '0;
    end else if (step) begin
      pos_r      <= nxt.len;
      type_r     <= nxt.type_code;
      rsv_r      <= nxt.reserved_nonzero;
      ovf_r      <= nxt.length_overflow;
      sender_r   <= nxt.sender;
      receiver_r <= nxt.receiver;
      counter_r  <= nxt.counter;
    end
  end

endmodule

### rtl/tdhp_decode.sv
// Final-byte decision: length and prefix checks, kind and reported fields.
`timescale 1ns / 1ps

module tdhp_decode
  import tdhp_pkg::*;
(
  input  tdhp_view_t   view,
  output tdhp_result_t result
);

  logic ok;

  always_comb begin
    ok = (view.len >= PREFIX_LEN) && !view.reserved_nonzero && !view.length_overflow;

    result                 = '0;
    result.datagram_length = view.len;

    if (ok) begin
      case (view.type_code)
        TYPE_INIT: begin
          if (view.len == INIT_SIZE) begin
            result.accepted     = 1'b1;
            result.message_kind = KIND_INIT;
            result.sender_id    = view.sender;
            result.mac1_offset  = INIT_MAC1;
            result.mac2_offset  = INIT_MAC2;
          end
        end
        TYPE_RESP: begin
          if (view.len == RESP_SIZE) begin
            result.accepted     = 1'b1;
            result.message_kind = KIND_RESP;
            result.sender_id    = view.sender;
            result.receiver_id  = view.receiver;
            result.mac1_offset  = RESP_MAC1;
            result.mac2_offset  = RESP_MAC2;
          end
        end
        TYPE_COOKIE: begin
          if (view.len == COOKIE_SIZE) begin
            result.accepted     = 1'b1;
            result.message_kind = KIND_COOKIE;
            result.receiver_id  = view.receiver;
          end
        end
        TYPE_DATA: begin
          if (view.len >= DATA_MIN_SIZE) begin
            result.accepted      = 1'b1;
            result.message_kind  = KIND_DATA;
            result.receiver_id   = view.receiver;
            result.nonce_counter = view.counter;
            result.sealed_length = view.len - DATA_HEADER;
          end
        end
        default: begin
          result.accepted = 1'b0;
        end
      endcase
    end
  end

endmodule

### rtl/tunnel_datagram_header_parser_core.sv
// Top level of the tunnel datagram header parser: byte register, accumulator, result register.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid, in_ready, in_data_byte, ...   | request in, one byte each
//   out     | out_valid, out_ready, out_accepted, ... | one result per final byte
//
// Throughput is one byte per cycle unless a final byte waits on a full result register.
// out_valid rises once the final byte has passed from the byte register into the
// result register.
// Synchronous active-low reset clears the handshake and all per-datagram state.
// A stalled result only holds back a waiting final byte; other bytes keep
// flowing while the result register is full.
`timescale 1ns / 1ps

module tunnel_datagram_header_parser_core
  import tdhp_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_accepted,
  output logic [1:0]  out_message_kind,
  output logic [31:0] out_sender_id,
  output logic [31:0] out_receiver_id,
  output logic [63:0] out_nonce_counter,
  output logic [15:0] out_datagram_length,
  output logic [15:0] out_sealed_length,
  output logic [7:0]  out_mac1_offset,
  output logic [7:0]  out_mac2_offset
);

  `include "assert_macros.svh"

  logic         in_valid_r;
  logic [7:0]   in_byte_r;
  logic         in_last_r;
  logic         out_valid_r;
  tdhp_result_t out_r;

  logic         advance;
  tdhp_view_t   view;
  tdhp_result_t result;

  logic         final_held;
  logic         out_is_data;
  logic         rej_fields_zero;
  logic         sealed_match;

  // A byte moves on unless it is final and the result register is blocked
  assign advance  = in_valid_r && (!in_last_r || !out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  // Input byte register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_data_byte;
      in_last_r <= in_last_byte;
    end
  end

  tdhp_gather #(
    .MAX_LEN (MAX_LEN)
  ) u_gather (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .data_byte (in_byte_r),
    .last_byte (in_last_r),
    .view      (view)
  );

  tdhp_decode u_decode (
    .view   (view),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last_r) begin
      out_r <= result;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_accepted        = out_r.accepted;
  assign out_message_kind    = out_r.message_kind;
  assign out_sender_id       = out_r.sender_id;
  assign out_receiver_id     = out_r.receiver_id;
  assign out_nonce_counter   = out_r.nonce_counter;
  assign out_datagram_length = out_r.datagram_length;
  assign out_sealed_length   = out_r.sealed_length;
  assign out_mac1_offset     = out_r.mac1_offset;
  assign out_mac2_offset     = out_r.mac2_offset;

  // Checks
  assign final_held      = in_valid_r && in_last_r;
  assign out_is_data     = out_valid && out_accepted && (out_message_kind == KIND_DATA);
  assign rej_fields_zero = (out_message_kind == KIND_INIT) && (out_sender_id == 32'd0) &&
                           (out_receiver_id == 32'd0) && (out_nonce_counter == 64'd0) &&
                           (out_sealed_length == 16'd0) && (out_mac1_offset == 8'd0) &&
                           (out_mac2_offset == 8'd0);
  assign sealed_match    = out_sealed_length == (out_datagram_length - DATA_HEADER);

  `TDHP_ASSERT_NOW(a_reject_clean, out_valid && !out_accepted, rej_fields_zero, "reject not clean")
  `TDHP_ASSERT_NOW(a_sealed_len, out_is_data, sealed_match, "sealed length mismatch")
  `TDHP_ASSERT_NOW(a_result_src, $rose(out_valid_r), $past(final_held), "result with no final byte")
  `TDHP_ASSERT_NEXT(a_final_load, advance && in_last_r, out_valid_r, "final byte not loaded")

endmodule

### tb/sv/tunnel_datagram_header_parser_core_tb.sv
// Self-checking testbench for the tunnel datagram header parser core.
`timescale 1ns / 1ps

module tunnel_datagram_header_parser_core_tb;
  import tdhp_pkg::*;

  localparam int MAX_LEN = MAX_LEN_DEF;

  // One byte request as queued for the driver
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       hold;   // wait for all results to drain before presenting
  } wire_byte_t;

  // Header fields gathered so far for the datagram in progress
  typedef struct {
    logic [15:0] pos;
    logic [7:0]  tcode;
    bit          rsv_nz;
    bit          ovf;
    logic [31:0] sender;
    logic [31:0] receiver;
    logic [63:0] counter;
  } hdr_state_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_accepted;
  logic [1:0]  out_message_kind;
  logic [31:0] out_sender_id;
  logic [31:0] out_receiver_id;
  logic [63:0] out_nonce_counter;
  logic [15:0] out_datagram_length;
  logic [15:0] out_sealed_length;
  logic [7:0]  out_mac1_offset;
  logic [7:0]  out_mac2_offset;

  wire_byte_t   wire_bytes_q[$];
  tdhp_result_t verdict_q[$];
  hdr_state_t   hdr;
  int           total_bytes = 0;
  int           total_dgrams = 0;
  int           bytes_done = 0;
  int           dgrams_done = 0;
  int           fails = 0;

  tunnel_datagram_header_parser_core uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .in_last_byte        (in_last_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_accepted        (out_accepted),
    .out_message_kind    (out_message_kind),
    .out_sender_id       (out_sender_id),
    .out_receiver_id     (out_receiver_id),
    .out_nonce_counter   (out_nonce_counter),
    .out_datagram_length (out_datagram_length),
    .out_sealed_length   (out_sealed_length),
    .out_mac1_offset     (out_mac1_offset),
    .out_mac2_offset     (out_mac2_offset)
  );

  always #4 clk = ~clk;

  function automatic void clear_hdr();
    hdr.pos      = '0;
    hdr.tcode    = '0;
    hdr.rsv_nz   = 1'b0;
    hdr.ovf      = 1'b0;
    hdr.sender   = '0;
    hdr.receiver = '0;
    hdr.counter  = '0;
  endfunction

  // Parser prediction: fold one accepted byte in, queue a verdict on the final byte
  function automatic void parse_byte(logic [7:0] b, logic last);
    int           p;
    logic [7:0]   t;
    tdhp_result_t r;
    bit           ok;
    p = int'(hdr.pos);
    if (p == 0) hdr.tcode = b;
    else if (p < 4 && b != 8'h00) hdr.rsv_nz = 1'b1;
    t = hdr.tcode;

    // little-endian index and counter capture
    if (p >= 4 && p < 8) begin
      if (t == TYPE_INIT || t == TYPE_RESP) hdr.sender[8*(p-4) +: 8] = b;
      else if (t == TYPE_COOKIE || t == TYPE_DATA) hdr.receiver[8*(p-4) +: 8] = b;
    end else if (p >= 8 && p < 16) begin
      if (t == TYPE_RESP && p < 12) hdr.receiver[8*(p-8) +: 8] = b;
      else if (t == TYPE_DATA) hdr.counter[8*(p-8) +: 8] = b;
    end

    if (hdr.pos < MAX_LEN) hdr.pos = hdr.pos + 16'd1;
    else hdr.ovf = 1'b1;

    if (last) begin
      r = '0;
      r.datagram_length = hdr.pos;
      ok = hdr.pos >= PREFIX_LEN && !hdr.rsv_nz && !hdr.ovf;
      if (ok) begin
        if (t == TYPE_INIT && hdr.pos == INIT_SIZE) begin
          r.accepted     = 1'b1;
          r.message_kind = KIND_INIT;
          r.sender_id    = hdr.sender;
          r.mac1_offset  = INIT_MAC1;
          r.mac2_offset  = INIT_MAC2;
        end else if (t == TYPE_RESP && hdr.pos == RESP_SIZE) begin
          r.accepted     = 1'b1;
          r.message_kind = KIND_RESP;
          r.sender_id    = hdr.sender;
          r.receiver_id  = hdr.receiver;
          r.mac1_offset  = RESP_MAC1;
          r.mac2_offset  = RESP_MAC2;
        end else if (t == TYPE_COOKIE && hdr.pos == COOKIE_SIZE) begin
          r.accepted     = 1'b1;
          r.message_kind = KIND_COOKIE;
          r.receiver_id  = hdr.receiver;
        end else if (t == TYPE_DATA && hdr.pos >= DATA_MIN_SIZE) begin
          r.accepted      = 1'b1;
          r.message_kind  = KIND_DATA;
          r.receiver_id   = hdr.receiver;
          r.nonce_counter = hdr.counter;
          r.sealed_length = hdr.pos - DATA_HEADER;
        end
      end
      verdict_q.push_back(r);
      clear_hdr();
    end
  endfunction

  // Queue one datagram; bad_rsv picks a reserved byte to spoil (0 none, -1 random)
  task automatic add_datagram(input logic [7:0] tcode, input int len, input int bad_rsv,
                              input bit hold);
    wire_byte_t wb;
    for (int i = 0; i < len; i++) begin
      if (i == 0) wb.data = tcode;
      else if (i < 4) begin
        if (bad_rsv == -1) wb.data = 8'($urandom_range(0, 255));
        else if (bad_rsv == i) wb.data = 8'($urandom_range(1, 255));
        else wb.data = 8'h00;
      end else wb.data = 8'($urandom_range(0, 255));
      wb.last = (i == len - 1);
      wb.hold = hold && (i == 0);
      wire_bytes_q.push_back(wb);
    end
    total_bytes += len;
    total_dgrams++;
  endtask

  // Idle percentages by thirds of the run: receiver-heavy, sender-heavy, none
  function automatic int sender_idle_pct();
    if (dgrams_done * 3 < total_dgrams) return 21;
    else if (dgrams_done * 3 < total_dgrams * 2) return 45;
    else return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (dgrams_done * 3 < total_dgrams) return 45;
    else if (dgrams_done * 3 < total_dgrams * 2) return 21;
    else return 0;
  endfunction

  function automatic void check_field(string fname, logic [63:0] e, logic [63:0] a);
    if (a !== e) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, e, a);
      fails++;
    end
  endfunction

  // Driver: present queued byte requests, feed accepted ones to the predictor
  always @(posedge clk) begin
    wire_byte_t nxt;
    bit         take;
    bit         go;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      take = in_valid && in_ready;
      if (take) begin
        parse_byte(in_data_byte, in_last_byte);
        bytes_done++;
        if (in_last_byte) dgrams_done++;
      end
      if (!in_valid || take) begin
        go = wire_bytes_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct();
        if (go && wire_bytes_q[0].hold && verdict_q.size() != 0) go = 1'b0;
        if (go) begin
          nxt = wire_bytes_q.pop_front();
          in_data_byte <= nxt.data;
          in_last_byte <= nxt.last;
          in_valid     <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest verdict
  always @(posedge clk) begin
    tdhp_result_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, actual length %0d",
                   $time, out_datagram_length);
          fails++;
        end else begin
          e = verdict_q.pop_front();
          check_field("accepted", e.accepted, out_accepted);
          check_field("message_kind", e.message_kind, out_message_kind);
          check_field("sender_id", e.sender_id, out_sender_id);
          check_field("receiver_id", e.receiver_id, out_receiver_id);
          check_field("nonce_counter", e.nonce_counter, out_nonce_counter);
          check_field("datagram_length", e.datagram_length, out_datagram_length);
          check_field("sealed_length", e.sealed_length, out_sealed_length);
          check_field("mac1_offset", e.mac1_offset, out_mac1_offset);
          check_field("mac2_offset", e.mac2_offset, out_mac2_offset);
        end
      end
      out_ready <= $urandom_range(0, 99) >= receiver_idle_pct();
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int rnd_cnt;
    int roll;
    int len;
    bit hold;
    logic [7:0] t;
    clear_hdr();

    // directed: each kind at its size, size edges, bad prefixes, short datagrams
    add_datagram(TYPE_INIT, 148, 0, 1'b0);
    add_datagram(TYPE_RESP, 92, 0, 1'b0);
    add_datagram(TYPE_COOKIE, 64, 0, 1'b0);
    add_datagram(TYPE_DATA, 32, 0, 1'b0);
    add_datagram(TYPE_DATA, 31, 0, 1'b0);
    add_datagram(TYPE_INIT, 147, 0, 1'b0);
    add_datagram(TYPE_RESP, 93, 0, 1'b0);
    add_datagram(TYPE_COOKIE, 63, 0, 1'b0);
    add_datagram(8'h00, 32, 0, 1'b0);
    add_datagram(8'hFF, 64, 0, 1'b0);
    add_datagram(8'h05, 40, 0, 1'b0);
    add_datagram(TYPE_DATA, 1, 0, 1'b0);
    add_datagram(TYPE_INIT, 2, 0, 1'b0);
    add_datagram(TYPE_DATA, 3, 0, 1'b0);
    add_datagram(TYPE_DATA, 4, 0, 1'b0);
    add_datagram(TYPE_DATA, 40, 1, 1'b0);
    add_datagram(TYPE_DATA, 40, 2, 1'b0);
    add_datagram(TYPE_DATA, 40, 3, 1'b0);
    add_datagram(TYPE_INIT, 149, 0, 1'b1);

    // random: mostly well-formed datagrams with random content, the rest mostly broken
    rnd_cnt = 0;
    while (total_bytes < 1550) begin
      roll = $urandom_range(0, 99);
      hold = (rnd_cnt == 0) || ($urandom_range(0, 19) == 0);
      if (roll < 15) begin
        t = TYPE_INIT;
        len = 148;
      end else if (roll < 30) begin
        t = TYPE_RESP;
        len = 92;
      end else if (roll < 45) begin
        t = TYPE_COOKIE;
        len = 64;
      end else if (roll < 75) begin
        t = TYPE_DATA;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(73, 300) : $urandom_range(32, 72);
      end else begin
        t = 8'($urandom_range(1, 4));
        len = $urandom_range(1, 160);
        if (roll < 82) t = 8'($urandom_range(0, 255));
        else if (roll < 90) len = (t == TYPE_INIT) ? 148 : (t == TYPE_RESP) ? 92 : 64;
        else if (roll < 95) len = $urandom_range(1, 3);
        else if (t == TYPE_DATA) len = $urandom_range(4, 31);
      end
      if (roll >= 82 && roll < 90) add_datagram(t, len, $urandom_range(1, 3), hold);
      else if (roll >= 75 && roll < 82) add_datagram(t, len, -1, hold);
      else add_datagram(t, len, 0, hold);
      rnd_cnt++;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // drain: every byte taken and every verdict matched, then let the pipe settle
    do @(negedge clk);
    while (bytes_done != total_bytes || verdict_q.size() != 0);
    repeat (16) @(posedge clk);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/tdhp_pkg.sv
rtl/tdhp_gather.sv
rtl/tdhp_decode.sv
rtl/tunnel_datagram_header_parser_core.sv
tb/sv/tunnel_datagram_header_parser_core_tb.sv
